// File: hw/rtl/rtcc_pkg.sv
`default_nettype none

package rtcc_pkg;

    // Calendar counters, one snapshot of the time and date
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam logic [5:0]  SEC_LAST      = 6'd59;
    localparam logic [5:0]  MIN_LAST      = 6'd59;
    localparam logic [4:0]  HOUR_LAST     = 5'd23;
    localparam logic [3:0]  MONTH_LAST    = 4'd12;
    localparam logic [13:0] YEAR_LAST     = 14'd9999;
    localparam logic [4:0]  DAY_FIRST     = 5'd1;
    localparam logic [3:0]  MONTH_FIRST   = 4'd1;
    localparam logic [5:0]  TRIM_SEC_ODD  = 6'd58;
    localparam logic [5:0]  TRIM_SEC_EVEN = 6'd57;

    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_APR = 4'd4;
    localparam logic [3:0]  MONTH_JUN = 4'd6;
    localparam logic [3:0]  MONTH_SEP = 4'd9;
    localparam logic [3:0]  MONTH_NOV = 4'd11;

    // Quotient by 100 through a reciprocal, exact below 43699
    function automatic logic [7:0] div100(input logic [13:0] y);
        logic [26:0] p;
        p = 27'(y) * 27'(5243);
        return p[26:19];
    endfunction

    function automatic logic [13:0] times100(input logic [7:0] q);
        return 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
    endfunction

    // Gregorian rule: by 400, or by 4 and not by 100
    function automatic logic is_leap(input logic [13:0] y);
        logic [7:0] q;
        logic       hundred;
        q       = div100(y);
        hundred = (y == times100(q));
        return (hundred && (q[1:0] == 2'b00)) || (!hundred && (y[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m) inside
            MONTH_FEB: d = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // Two BCD digits of v: tens taken mod 10, valid for v below 200
    function automatic logic [7:0] bcd_byte(input logic [7:0] v);
        logic [18:0] p;
        logic [7:0]  t;
        logic [7:0]  o;
        p = 19'(v) * 19'(205);
        t = p[18:11];
        o = v - (8'({t, 3'b0}) + 8'({t, 1'b0}));
        if (t >= 8'd10) begin
            t = t - 8'd10;
        end
        return {t[3:0], o[3:0]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtc_calendar_tick_with_drift_trim_core.sv
// Real-time clock calendar with drift trim.
// Input channel (s_*): one request per second tick or per time/date load.
//   s_tuser selects the kind: tick advances the calendar one second,
//   load overwrites time and date but keeps the trim flag and colon phase.
// Output channel (m_*): one result per request, carrying the time and
//   date as BCD digits, minutes of day and the colon phase after the update.
// Pipeline: the result passes the calendar, hundreds and output registers; the
//   calendar itself updates in the cycle the request is accepted.
// Throughput: one request per cycle while the output is not stalled. The
//   calendar update is combinational; BCD formatting runs in two further pipeline stages.
// Stall: each stage holds its contents while the next one is full; with the
//   output stalled, up to two more requests are still taken before s_tready
//   drops. Nothing is dropped or repeated.
// Reset: clears the pipeline; calendar goes to 00:00:00 on day 1, month 1,
//   year 0, trim armed, colon phase low.
`default_nettype none

module rtc_calendar_tick_with_drift_trim_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // load_year[13:0], load_month[17:14], load_day[22:18], load_hour[27:23],
    // load_minute[33:28], load_second[39:34]
    input  wire logic [39:0] s_tdata,
    // mode[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // year_bcd[15:0], month_bcd[23:16], day_bcd[31:24], hour_bcd[39:32],
    // minute_bcd[47:40], second_bcd[55:48], minutes_of_day[66:56],
    // colon_phase[67], zero[71:68]
    output logic [71:0]      m_tdata
);

    rtcc_pkg::cal_t cal_reg;
    rtcc_pkg::cal_t cal_next;
    logic           trim_armed_reg;
    logic           trim_armed_next;
    logic           blink_reg;
    logic           blink_next;
    logic           valid_reg;

    logic           fmt_ready;
    logic           accept;
    logic [4:0]     mdays;
    logic [5:0]     sec_trim;

    // The calendar register doubles as the first pipeline stage
    assign s_tready = !valid_reg || fmt_ready;
    assign accept   = s_tvalid && s_tready;

    assign mdays = rtcc_pkg::month_days(cal_reg.month, rtcc_pkg::is_leap(cal_reg.year));

    always_comb begin
        cal_next        = cal_reg;
        trim_armed_next = trim_armed_reg;
        blink_next      = blink_reg;
        sec_trim        = cal_reg.second;
        if (accept) begin
            if (s_tuser[0] == rtcc_pkg::MODE_LOAD) begin
                cal_next.year   = s_tdata[13:0];
                cal_next.month  = s_tdata[17:14];
                cal_next.day    = s_tdata[22:18];
                cal_next.hour   = s_tdata[27:23];
                cal_next.minute = s_tdata[33:28];
                cal_next.second = s_tdata[39:34];
            end
            else begin
                // drift trim: repeat second 59 of the hour on odd hours, seconds 58 and 59 on even hours
                if (trim_armed_reg && cal_reg.minute == rtcc_pkg::MIN_LAST
                        && cal_reg.second == rtcc_pkg::SEC_LAST) begin
                    sec_trim        = cal_reg.hour[0] ? rtcc_pkg::TRIM_SEC_ODD
                                                      : rtcc_pkg::TRIM_SEC_EVEN;
                    trim_armed_next = 1'b0;
                end
                blink_next = ~blink_reg;
                if (sec_trim < rtcc_pkg::SEC_LAST) begin
                    cal_next.second = sec_trim + 6'd1;
                end
                else begin
                    cal_next.second = '0;
                    trim_armed_next = 1'b1;
                    if (cal_reg.minute < rtcc_pkg::MIN_LAST) begin
                        cal_next.minute = cal_reg.minute + 6'd1;
                    end
                    else begin
                        cal_next.minute = '0;
                        if (cal_reg.hour < rtcc_pkg::HOUR_LAST) begin
                            cal_next.hour = cal_reg.hour + 5'd1;
                        end
                        else begin
                            cal_next.hour = '0;
                            if (cal_reg.day < mdays) begin
                                cal_next.day = cal_reg.day + 5'd1;
                            end
                            else begin
                                cal_next.day = rtcc_pkg::DAY_FIRST;
                                if (cal_reg.month < rtcc_pkg::MONTH_LAST) begin
                                    cal_next.month = cal_reg.month + 4'd1;
                                end
                                else begin
                                    cal_next.month = rtcc_pkg::MONTH_FIRST;
                                    if (cal_reg.year < rtcc_pkg::YEAR_LAST) begin
                                        cal_next.year = cal_reg.year + 14'd1;
                                    end
                                    else begin
                                        cal_next.year = '0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cal_reg.year   <= '0;
            cal_reg.month  <= rtcc_pkg::MONTH_FIRST;
            cal_reg.day    <= rtcc_pkg::DAY_FIRST;
            cal_reg.hour   <= '0;
            cal_reg.minute <= '0;
            cal_reg.second <= '0;
            trim_armed_reg <= 1'b1;
            blink_reg      <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else begin
            cal_reg        <= cal_next;
            trim_armed_reg <= trim_armed_next;
            blink_reg      <= blink_next;
            // hold the snapshot until the formatter takes it
            if (s_tready) begin
                valid_reg <= s_tvalid;
            end
        end
    end

    rtcc_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg),
        .in_ready  (fmt_ready),
        .in_cal    (cal_reg),
        .in_blink  (blink_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rtcc_fmt.sv
`default_nettype none

// Two-stage display formatter: split the year into hundreds and the other fields into BCD, then the year into BCD
module rtcc_fmt (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire rtcc_pkg::cal_t in_cal,
    input  wire logic          in_blink,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [71:0]        out_data
);

    logic        s2_valid_reg;
    logic [7:0]  yq_reg;
    logic [6:0]  yr_reg;
    logic [7:0]  month_bcd_reg;
    logic [7:0]  day_bcd_reg;
    logic [7:0]  hour_bcd_reg;
    logic [7:0]  minute_bcd_reg;
    logic [7:0]  second_bcd_reg;
    logic [10:0] mod_reg;
    logic        blink2_reg;

    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    logic        s2_ready;
    logic        s3_ready;
    logic [7:0]  yq;
    logic [13:0] yr_wide;
    logic [10:0] mod;

    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    assign yq      = rtcc_pkg::div100(in_cal.year);
    assign yr_wide = in_cal.year - rtcc_pkg::times100(yq);
    // hour * 60 + minute, by shifts
    assign mod = {in_cal.hour, 6'b0} - {4'b0, in_cal.hour, 2'b0} + {5'b0, in_cal.minute};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (s2_ready) begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && s2_ready) begin
            yq_reg         <= yq;
            yr_reg         <= yr_wide[6:0];
            month_bcd_reg  <= rtcc_pkg::bcd_byte({4'b0, in_cal.month});
            day_bcd_reg    <= rtcc_pkg::bcd_byte({3'b0, in_cal.day});
            hour_bcd_reg   <= rtcc_pkg::bcd_byte({3'b0, in_cal.hour});
            minute_bcd_reg <= rtcc_pkg::bcd_byte({2'b0, in_cal.minute});
            second_bcd_reg <= rtcc_pkg::bcd_byte({2'b0, in_cal.second});
            mod_reg        <= mod;
            blink2_reg     <= in_blink;
        end
        if (s2_valid_reg && s3_ready) begin
            out_data_reg <= {4'b0, blink2_reg, mod_reg, second_bcd_reg, minute_bcd_reg,
                             hour_bcd_reg, day_bcd_reg, month_bcd_reg,
                             rtcc_pkg::bcd_byte(yq_reg),
                             rtcc_pkg::bcd_byte({1'b0, yr_reg})};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
